[hdl/kwm_pkg.sv]
// types, constants and cell control structs for the k-way merge selector
package kwm_pkg;

    localparam int MAX_WAYS = 8;
    localparam int WAY_W    = 3;
    localparam int VAL_W    = 32;
    localparam int CFG_W    = 4;
    localparam int CNT_W    = $clog2(MAX_WAYS + 1);
    localparam int WAY_LIM  = (MAX_WAYS < (1 << WAY_W)) ? MAX_WAYS : (1 << WAY_W);

    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_EXHAUST = 1'b1;

    typedef struct packed {
        logic             active;
        logic             sel;
        logic             push;
        logic [VAL_W-1:0] value;
        logic             clr_head;
        logic             clr_all;
    } t_cell_ctrl;

    typedef struct packed {
        logic present;
        logic exhausted;
    } t_cell_stat;

    typedef struct packed {
        logic             go;
        logic             vld;
        logic [VAL_W-1:0] value;
        logic [WAY_W-1:0] way;
    } t_scan;

endpackage

[hdl/kwm_if.sv]
// valid/ready channel interfaces for input items, results and configuration
interface kwm_in_if;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [kwm_pkg::WAY_W-1:0] way;
    logic [kwm_pkg::VAL_W-1:0] value;

    modport source (output valid, output opcode, output way, output value, input ready);
    modport sink   (input valid, input opcode, input way, input value, output ready);
endinterface

interface kwm_res_if;
    logic                      valid;
    logic                      ready;
    logic [kwm_pkg::VAL_W-1:0] min_value;
    logic [kwm_pkg::WAY_W-1:0] source_way;
    logic                      done_res;

    modport source (output valid, output min_value, output source_way, output done_res,
                    input ready);
    modport sink   (input valid, input min_value, input source_way, input done_res,
                    output ready);
endinterface

interface kwm_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [kwm_pkg::CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/kwm_cell.sv]
// one way of the merge: head register, flags and one compare stage of the scan chain
module kwm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [kwm_pkg::WAY_W-1:0] i_idx,
    input  kwm_pkg::t_cell_ctrl       i_ctrl,
    input  kwm_pkg::t_scan            i_scan,
    output kwm_pkg::t_scan            o_scan,
    output kwm_pkg::t_cell_stat       o_stat
);

    logic [kwm_pkg::VAL_W-1:0] r_head;
    logic                      r_present;
    logic                      r_exhausted;
    kwm_pkg::t_scan            r_scan;
    logic                      w_take;

    // strict less keeps the lower way on ties
    assign w_take = i_ctrl.active && r_present &&
                    (!i_scan.vld || ($signed(r_head) < $signed(i_scan.value)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= 1'b0;
            r_exhausted <= 1'b0;
        end else if (i_ctrl.clr_all) begin
            r_present   <= 1'b0;
            r_exhausted <= 1'b0;
        end else begin
            if (i_ctrl.sel && i_ctrl.push && !r_exhausted) begin
                r_present <= 1'b1;
            end
            if (i_ctrl.sel && !i_ctrl.push) begin
                r_exhausted <= 1'b1;
            end
            if (i_ctrl.clr_head) begin
                r_present <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sel && i_ctrl.push && !r_exhausted) begin
            r_head <= i_ctrl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.go <= 1'b0;
        end else begin
            r_scan.go <= i_scan.go;
            if (i_scan.go) begin
                if (w_take) begin
                    r_scan.vld   <= 1'b1;
                    r_scan.value <= r_head;
                    r_scan.way   <= i_idx;
                end else begin
                    r_scan.vld   <= i_scan.vld;
                    r_scan.value <= i_scan.value;
                    r_scan.way   <= i_scan.way;
                end
            end
        end
    end

    assign o_scan           = r_scan;
    assign o_stat.present   = r_present;
    assign o_stat.exhausted = r_exhausted;

endmodule

[hdl/k_way_merge_selector.sv]
// top level of the k-way merge selector: control, cell chain and result register
//
//  channel  dir  beat contents
//  i_in     in   opcode, way, value
//  o_res    out  min_value, source_way, done_res
//  i_cfg    in   active_ways (data)
//
// an item passes from accept through the readiness check, then the scan token walks the chain
// one cell at a time, and the finish state loads its result.
// an item that leaves some active way unfilled returns to idle after the check.
// reset clears all flags and sets active_ways to the full way count.
// i_in is taken only while idle; a result waiting on o_res does not block the next item,
// but a finished scan holds in finish until the result register is free.
module k_way_merge_selector (
    input  logic            i_clk,
    input  logic            i_rst_n,
    kwm_in_if.sink          i_in,
    kwm_res_if.source       o_res,
    kwm_cfg_if.sink         i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                        r_state;
    logic [kwm_pkg::CNT_W-1:0]     r_ways;
    logic [kwm_pkg::CNT_W-1:0]     n_ways;
    logic                          r_out_valid;
    logic [kwm_pkg::VAL_W-1:0]     r_out_value;
    logic [kwm_pkg::WAY_W-1:0]     r_out_way;
    logic                          r_out_done;

    kwm_pkg::t_cell_ctrl           w_ctrl [kwm_pkg::MAX_WAYS];
    kwm_pkg::t_cell_stat           w_stat [kwm_pkg::MAX_WAYS];
    kwm_pkg::t_scan                w_scan [kwm_pkg::MAX_WAYS + 1];
    logic [kwm_pkg::MAX_WAYS-1:0]  w_present;
    logic [kwm_pkg::MAX_WAYS-1:0]  w_exhausted;
    logic [kwm_pkg::MAX_WAYS-1:0]  w_go;
    logic                          w_all_ready;
    logic                          w_in_acc;
    logic                          w_load;
    kwm_pkg::t_scan                w_best;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_best      = w_scan[kwm_pkg::MAX_WAYS];
    assign w_load      = (r_state == S_FINISH) && (!r_out_valid || o_res.ready);

    // clamp the way count to 1..limit
    always_comb begin
        if (i_cfg.data == '0) begin
            n_ways = kwm_pkg::CNT_W'(1);
        end else if (kwm_pkg::CNT_W'(i_cfg.data) > kwm_pkg::CNT_W'(kwm_pkg::WAY_LIM)) begin
            n_ways = kwm_pkg::CNT_W'(kwm_pkg::WAY_LIM);
        end else begin
            n_ways = kwm_pkg::CNT_W'(i_cfg.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways <= kwm_pkg::CNT_W'(kwm_pkg::WAY_LIM);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_ways <= n_ways;
        end
    end

    always_comb begin
        for (int j = 0; j < kwm_pkg::MAX_WAYS; j++) begin
            w_ctrl[j].active   = (kwm_pkg::CNT_W'(j) < r_ways);
            w_ctrl[j].sel      = w_in_acc && w_ctrl[j].active &&
                                 (i_in.way == kwm_pkg::WAY_W'(j));
            w_ctrl[j].push     = (i_in.opcode == kwm_pkg::OP_PUSH);
            w_ctrl[j].value    = i_in.value;
            w_ctrl[j].clr_head = w_load && w_best.vld && (w_best.way == kwm_pkg::WAY_W'(j));
            w_ctrl[j].clr_all  = w_load && !w_best.vld;
        end
    end

    always_comb begin
        w_all_ready = 1'b1;
        for (int j = 0; j < kwm_pkg::MAX_WAYS; j++) begin
            w_present[j]   = w_stat[j].present;
            w_exhausted[j] = w_stat[j].exhausted;
            w_go[j]        = w_scan[j + 1].go;
            if (w_ctrl[j].active && !w_stat[j].present && !w_stat[j].exhausted) begin
                w_all_ready = 1'b0;
            end
        end
    end

    // scan token enters the first cell with no candidate
    assign w_scan[0].go    = (r_state == S_CHECK) && w_all_ready;
    assign w_scan[0].vld   = 1'b0;
    assign w_scan[0].value = '0;
    assign w_scan[0].way   = '0;

    for (genvar g = 0; g < kwm_pkg::MAX_WAYS; g++) begin : g_cell
        kwm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (kwm_pkg::WAY_W'(g)),
            .i_ctrl  (w_ctrl[g]),
            .i_scan  (w_scan[g]),
            .o_scan  (w_scan[g + 1]),
            .o_stat  (w_stat[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= w_all_ready ? S_SCAN : S_IDLE;
                end
                S_SCAN: begin
                    if (w_best.go) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= w_best.vld ? w_best.value : '0;
            r_out_way   <= w_best.vld ? w_best.way : '0;
            r_out_done  <= !w_best.vld;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.min_value  = r_out_value;
    assign o_res.source_way = r_out_way;
    assign o_res.done_res   = r_out_done;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_go))
        else $error("more than one scan token in the cell chain");

    a_idle_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_go == '0))
        else $error("scan token alive while idle");

    a_load_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result loaded outside finish");

    a_emit_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && w_best.vld) |-> w_present[w_best.way])
        else $error("emitted head was not present");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_best.vld) |=> (w_present == '0 && w_exhausted == '0))
        else $error("flags not cleared after done");

endmodule

[sim/tb_top.sv]
// testbench for k_way_merge_selector: merge scoreboard, random merge traffic and result checks
typedef struct packed {
    logic signed [kwm_pkg::VAL_W-1:0] min_value;
    logic [kwm_pkg::WAY_W-1:0]        source_way;
    logic                             done_res;
} t_merge_out;

class merge_scoreboard;
    bit signed [kwm_pkg::VAL_W-1:0] head_val [kwm_pkg::MAX_WAYS];
    bit                             head_pres [kwm_pkg::MAX_WAYS];
    bit                             way_exh [kwm_pkg::MAX_WAYS];
    bit [kwm_pkg::CFG_W-1:0]        ways_reg;
    t_merge_out                     pending_out[$];
    int                             errors;
    int                             n_items;
    int                             n_live;
    int                             n_elem;
    int                             n_done;

    function new();
        foreach (head_val[i]) begin
            head_val[i]  = '0;
            head_pres[i] = 1'b0;
            way_exh[i]   = 1'b0;
        end
        ways_reg = kwm_pkg::CFG_W'(kwm_pkg::MAX_WAYS);
    endfunction

    function int live_ways();
        if (ways_reg == 0)
            return 1;
        if (ways_reg > kwm_pkg::WAY_LIM)
            return kwm_pkg::WAY_LIM;
        return int'(ways_reg);
    endfunction

    // apply one accepted beat and queue the element or done marker it releases
    function bit take_item(input bit op, input bit [kwm_pkg::WAY_W-1:0] w,
                           input bit [kwm_pkg::VAL_W-1:0] v, output t_merge_out r);
        int n;
        int best;
        bit any_head;
        n        = live_ways();
        r        = '0;
        best     = 0;
        any_head = 1'b0;
        n_items++;
        if (int'(w) < n) begin
            n_live++;
            if (op == kwm_pkg::OP_PUSH) begin
                if (!way_exh[w]) begin
                    head_val[w]  = v;
                    head_pres[w] = 1'b1;
                end
            end else begin
                way_exh[w] = 1'b1;
            end
        end
        for (int i = 0; i < n; i++)
            if (!head_pres[i] && !way_exh[i])
                return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (head_pres[i]) begin
                if (!any_head || head_val[i] < head_val[best])
                    best = i;
                any_head = 1'b1;
            end
        end
        if (any_head) begin
            r.min_value  = head_val[best];
            r.source_way = best[kwm_pkg::WAY_W-1:0];
            head_pres[best] = 1'b0;
        end else begin
            r.done_res = 1'b1;
            foreach (head_pres[i]) begin
                head_pres[i] = 1'b0;
                way_exh[i]   = 1'b0;
            end
        end
        pending_out = {pending_out, r};
        return 1'b1;
    endfunction

    function void check_out(input t_merge_out seen);
        t_merge_out want;
        if (pending_out.size() == 0) begin
            $error("unexpected result beat: min_value %0d source_way %0d done_res %0d",
                   seen.min_value, seen.source_way, seen.done_res);
            errors++;
            return;
        end
        want = pending_out.pop_front();
        if (want.done_res)
            n_done++;
        else
            n_elem++;
        if (seen.min_value !== want.min_value) begin
            $error("min_value: expected %0d, got %0d", want.min_value, seen.min_value);
            errors++;
        end
        if (seen.source_way !== want.source_way) begin
            $error("source_way: expected %0d, got %0d", want.source_way, seen.source_way);
            errors++;
        end
        if (seen.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, seen.done_res);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam bit signed [kwm_pkg::VAL_W-1:0] INT_MAX = 32'sh7fffffff;
    localparam bit signed [kwm_pkg::VAL_W-1:0] INT_MIN = 32'sh80000000;
    localparam int DRAIN      = 3 * (3 + kwm_pkg::MAX_WAYS);
    localparam int LIMIT      = 600000;
    localparam int PHASE_BEATS = 60;

    logic i_clk;
    logic i_rst_n;

    kwm_in_if  in_ch();
    kwm_res_if res_ch();
    kwm_cfg_if cfg_ch();

    k_way_merge_selector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    merge_scoreboard                sb;
    bit                             calm;
    int                             cycles;
    bit signed [kwm_pkg::VAL_W-1:0] run_q [kwm_pkg::MAX_WAYS][$];
    int                             cfg_plan [12] = '{8, 1, 3, 0, 15, 5, 2, 7, 9, 4, 6, 8};

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit signed [kwm_pkg::VAL_W-1:0] rand_val();
        case ($urandom_range(0, 9))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2, 3:    return kwm_pkg::VAL_W'(int'($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input bit op, input bit [kwm_pkg::WAY_W-1:0] w,
                        input bit [kwm_pkg::VAL_W-1:0] v,
                        output bit got, output t_merge_out r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.way    <= w;
        in_ch.value  <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        got = sb.take_item(op, w, v, r);
    endtask

    task automatic put(input bit op, input bit [kwm_pkg::WAY_W-1:0] w,
                       input bit [kwm_pkg::VAL_W-1:0] v);
        bit got;
        t_merge_out r;
        send(op, w, v, got, r);
    endtask

    // let the pipeline drain before touching the register
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_cfg(input bit [kwm_pkg::CFG_W-1:0] d);
        settle();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.ways_reg = d;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic build_runs();
        int len;
        foreach (run_q[i]) begin
            run_q[i].delete();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 5);
            repeat (len) run_q[i] = {run_q[i], rand_val()};
            run_q[i].sort();
        end
    endtask

    // one full merge: refill whichever way is empty, with a little noise mixed in
    task automatic run_merge();
        bit         got;
        bit         finished;
        t_merge_out r;
        int         cand[$];
        int         n;
        int         pick;
        build_runs();
        calm     = ($urandom_range(0, 3) == 0);
        finished = 1'b0;
        while (!finished) begin
            n    = sb.live_ways();
            pick = 0;
            cand.delete();
            for (int i = 0; i < n; i++)
                if (!sb.head_pres[i] && !sb.way_exh[i])
                    cand = {cand, i};
            if ($urandom_range(0, 99) < 8) begin
                send(1'($urandom_range(0, 1)), kwm_pkg::WAY_W'($urandom_range(0, 7)),
                     rand_val(), got, r);
            end else if (cand.size() == 0) begin
                for (int i = 0; i < n; i++)
                    if (sb.way_exh[i])
                        pick = i;
                send(kwm_pkg::OP_EXHAUST, pick[kwm_pkg::WAY_W-1:0], $urandom, got, r);
            end else begin
                pick = cand[$urandom_range(0, cand.size() - 1)];
                if (run_q[pick].size() > 0)
                    send(kwm_pkg::OP_PUSH, pick[kwm_pkg::WAY_W-1:0], run_q[pick].pop_front(),
                         got, r);
                else
                    send(kwm_pkg::OP_EXHAUST, pick[kwm_pkg::WAY_W-1:0], $urandom, got, r);
            end
            if (got && r.done_res)
                finished = 1'b1;
        end
    endtask

    initial begin
        t_merge_out seen;
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 15);
            @(negedge i_clk);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            seen.min_value  = res_ch.min_value;
            seen.source_way = res_ch.source_way;
            seen.done_res   = res_ch.done_res;
            sb.check_out(seen);
        end
    end

    initial begin
        int start;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.opcode = kwm_pkg::OP_PUSH;
        in_ch.way    = '0;
        in_ch.value  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        res_ch.ready = 1'b0;
        cycles       = 0;
        calm         = 1'b0;
        sb           = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all eight ways: overwrite, ties, exhaust with head, push to exhausted way, extremes
        put(kwm_pkg::OP_PUSH, 0, 5);
        put(kwm_pkg::OP_PUSH, 0, -32'sd5);
        put(kwm_pkg::OP_PUSH, 3, -32'sd5);
        put(kwm_pkg::OP_EXHAUST, 3, 0);
        put(kwm_pkg::OP_EXHAUST, 1, 0);
        put(kwm_pkg::OP_EXHAUST, 2, 0);
        put(kwm_pkg::OP_EXHAUST, 4, 0);
        put(kwm_pkg::OP_EXHAUST, 5, 0);
        put(kwm_pkg::OP_PUSH, 6, INT_MIN);
        put(kwm_pkg::OP_PUSH, 7, INT_MAX);
        put(kwm_pkg::OP_EXHAUST, 6, 0);
        put(kwm_pkg::OP_EXHAUST, 0, 0);
        put(kwm_pkg::OP_PUSH, 2, 123);
        put(kwm_pkg::OP_EXHAUST, 7, 0);
        // two ways, inactive way addressed
        write_cfg(2);
        put(kwm_pkg::OP_PUSH, 5, 9);
        put(kwm_pkg::OP_PUSH, 0, 0);
        put(kwm_pkg::OP_PUSH, 1, 0);
        put(kwm_pkg::OP_EXHAUST, 0, 0);
        put(kwm_pkg::OP_EXHAUST, 1, 0);
        // shrink to one way in the middle of a merge
        put(kwm_pkg::OP_PUSH, 0, 7);
        write_cfg(1);
        put(kwm_pkg::OP_EXHAUST, 3, 0);
        put(kwm_pkg::OP_EXHAUST, 0, 0);

        foreach (cfg_plan[p]) begin
            write_cfg(kwm_pkg::CFG_W'(cfg_plan[p]));
            start = sb.n_live;
            while (sb.n_live - start < PHASE_BEATS)
                run_merge();
        end

        settle();
        $display("%0d input beats (%0d on active ways), %0d merged elements, %0d done markers",
                 sb.n_items, sb.n_live, sb.n_elem, sb.n_done);
        $display("way counts 1 through 8 and out-of-range settings 0, 9 and 15 exercised");
        if (sb.errors == 0 && sb.pending_out.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
